// ===== sv/lmfr_pkg.sv =====
package lmfr_pkg;

  localparam int unsigned RowCount = 8;
  localparam int unsigned RowWidth = 8;

  typedef logic [$clog2(RowCount)-1:0] row_idx_t;
  typedef logic [RowWidth-1:0] row_t;
  typedef logic [RowCount-1:0][RowWidth-1:0] frame_t;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_LOAD   = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic apply;  // frame edit from the accepted transaction
    logic emit;   // load the next remapped byte into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_row;
  } status_t;

  function automatic row_t rot_right1(row_t b);
    return {b[0], b[RowWidth-1:1]};
  endfunction

  function automatic row_t rot_left1(row_t b);
    return {b[RowWidth-2:0], b[RowWidth-1]};
  endfunction

  function automatic row_t bit_reverse(row_t b);
    row_t r;
    for (int i = 0; i < RowWidth; i++) begin
      r[RowWidth-1-i] = b[i];
    end
    return r;
  endfunction

  // Gather bit c of every row; msb_first puts row j at bit 7-j, else at bit j.
  function automatic row_t column_byte(frame_t f, row_idx_t c, logic msb_first);
    row_t r;
    for (int j = 0; j < RowCount; j++) begin
      if (msb_first) begin
        r[RowWidth-1-j] = f[j][c];
      end else begin
        r[j] = f[j][c];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/lmfr_in_if.sv =====
interface lmfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] pos_x;
  logic [3:0] pos_y;
  logic       pixel_on;
  logic [7:0] row_data;

  modport source (output valid, output action, output pos_x, output pos_y,
                  output pixel_on, output row_data, input ready);
  modport sink   (input valid, input action, input pos_x, input pos_y,
                  input pixel_on, input row_data, output ready);
endinterface

// ===== sv/lmfr_out_if.sv =====
interface lmfr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] ram_address;
  logic [7:0] ram_byte;
  logic       last;

  modport source (output valid, output ram_address, output ram_byte, output last,
                  input ready);
  modport sink   (input valid, input ram_address, input ram_byte, input last,
                  output ready);
endinterface

// ===== sv/lmfr_ctrl.sv =====
module lmfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_action,
  output logic             out_valid,
  input  logic             out_ready,
  output lmfr_pkg::cmd_t    cmd,
  input  lmfr_pkg::status_t status
);
  import lmfr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_UPDATE) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && status.last_row) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.apply = 1'b0;
    cmd.emit  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.apply = in_valid && in_action != ACT_UPDATE;
      end
      ST_EMIT: begin
        cmd.emit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Hold the output until taken; a fresh byte replaces it in the same cycle.
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== sv/lmfr_datapath.sv =====
module lmfr_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lmfr_pkg::cmd_t    cmd,
  output lmfr_pkg::status_t status,
  input  logic [1:0]        action,
  input  logic [3:0]        pos_x,
  input  logic [3:0]        pos_y,
  input  logic              pixel_on,
  input  logic [7:0]        row_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  output logic [3:0]        ram_address,
  output logic [7:0]        ram_byte,
  output logic              last
);
  import lmfr_pkg::*;

  frame_t   frame;
  frame_t   frame_next;
  rot_t     rotation;
  row_idx_t count;
  row_idx_t row_sel;
  row_t     sel_row;
  row_t     remap;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame    <= '0;
      rotation <= ROT_0;
      count    <= '0;
    end else begin
      frame <= frame_next;
      if (cfg_we) begin
        rotation <= rot_t'(cfg_data);
      end
      // Wraps back to row 0 after the last byte.
      if (cmd.emit) begin
        count <= count + row_idx_t'(1);
      end
    end
  end

  always_comb begin
    frame_next = frame;
    if (cmd.apply) begin
      case (action)
        ACT_DRAW: begin
          if (!pos_x[3] && !pos_y[3]) begin
            frame_next[pos_y[2:0]][~pos_x[2:0]] = pixel_on;
          end
        end
        ACT_FILL: begin
          for (int k = 0; k < RowCount; k++) begin
            frame_next[k] = {RowWidth{pixel_on}};
          end
        end
        ACT_LOAD: begin
          if (!pos_y[3]) begin
            frame_next[pos_y[2:0]] = row_data;
          end
        end
        default: frame_next = frame;
      endcase
    end
  end

  assign status.last_row = (count == row_idx_t'(RowCount - 1));

  // Rows are read bottom-up except for 270 degrees.
  assign row_sel = (rotation == ROT_270) ? count : ~count;
  assign sel_row = frame[row_sel];

  always_comb begin
    case (rotation)
      ROT_0:   remap = rot_right1(column_byte(frame, ~count, 1'b1));
      ROT_90:  remap = rot_right1(sel_row);
      ROT_180: remap = rot_right1(column_byte(frame, ~count, 1'b0));
      ROT_270: remap = bit_reverse(rot_left1(sel_row));
      default: remap = sel_row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ram_address <= {count, 1'b0};
      ram_byte    <= remap;
      last        <= status.last_row;
    end
  end

endmodule

// ===== sv/led_matrix_frame_rotator_top.sv =====
// 8x8 one-bit LED frame buffer. Draw, fill and load-row transactions produce
// no output. An update transaction streams the eight display-RAM bytes
// (addresses 0, 2, ... 14) through the output register, one per cycle while
// the sink is ready, with last set on the eighth; no input is taken until the
// eighth byte is loaded into the output register, so output stalls lengthen
// the update. Rotation is written through cfg_we/cfg_data and applies to the
// next update; write it only while the block is idle.
module led_matrix_frame_rotator_top (
  input  logic       clk,
  input  logic       rst,
  lmfr_in_if.sink    in_chan,
  lmfr_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);
  import lmfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  lmfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_action (in_chan.action),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .status    (status)
  );

  lmfr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .action      (in_chan.action),
    .pos_x       (in_chan.pos_x),
    .pos_y       (in_chan.pos_y),
    .pixel_on    (in_chan.pixel_on),
    .row_data    (in_chan.row_data),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .ram_address (out_chan.ram_address),
    .ram_byte    (out_chan.ram_byte),
    .last        (out_chan.last)
  );

endmodule

// ===== tb/led_matrix_frame_rotator_top_tb.sv =====
`timescale 1ns / 1ps

module led_matrix_frame_rotator_top_tb;
  import lmfr_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 20;
  localparam int HoldCycles = 300;

  typedef struct packed {
    action_t    action;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic       pixel_on;
    row_t       row_data;
  } frame_cmd_t;

  typedef struct packed {
    logic [3:0] ram_address;
    row_t       ram_byte;
    logic       last;
  } ram_write_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_data;

  lmfr_in_if  in_chan ();
  lmfr_out_if out_chan ();

  led_matrix_frame_rotator_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the frame and rotation, updated as transactions are accepted.
  row_t       shadow_rows [RowCount];
  rot_t       shadow_rot;
  ram_write_t ram_writes_due [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int cmds_sent = 0;
  int updates_sent = 0;
  int writes_checked = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_seen = 0;
  int sink_wait = 0;
  bit src_gaps_on = 1'b1;
  bit sink_gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever @(posedge clk) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles, %0d writes still due", cycle_count,
                 ram_writes_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Long output hold-off, started on request and counted down here so the sink
  // only has to look at it.
  always @(posedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen <= hold_requests;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic row_t ror1(row_t b);
    return {b[0], b[7:1]};
  endfunction

  function automatic row_t rol1(row_t b);
    return {b[6:0], b[7]};
  endfunction

  function automatic row_t mirror(row_t b);
    return {<<{b}};
  endfunction

  function automatic row_t column_of(int c, bit top_row_msb);
    row_t r;
    r = '0;
    for (int j = 0; j < RowCount; j++) begin
      if (shadow_rows[j][c]) r |= top_row_msb ? (8'h80 >> j) : (8'h01 << j);
    end
    return r;
  endfunction

  function automatic row_t remapped_row(int k);
    case (shadow_rot)
      ROT_0:   return ror1(column_of(7 - k, 1'b1));
      ROT_90:  return ror1(shadow_rows[7 - k]);
      ROT_180: return ror1(column_of(7 - k, 1'b0));
      default: return mirror(rol1(shadow_rows[k]));
    endcase
  endfunction

  function automatic void predict_frame_action(frame_cmd_t c);
    ram_write_t w;
    case (c.action)
      ACT_DRAW: begin
        if (c.pos_x < 8 && c.pos_y < 8) begin
          if (c.pixel_on) shadow_rows[c.pos_y[2:0]] |= (8'h80 >> c.pos_x);
          else shadow_rows[c.pos_y[2:0]] &= ~(8'h80 >> c.pos_x);
        end
      end
      ACT_FILL: begin
        foreach (shadow_rows[j]) shadow_rows[j] = c.pixel_on ? 8'hFF : 8'h00;
      end
      ACT_LOAD: begin
        if (c.pos_y < 8) shadow_rows[c.pos_y[2:0]] = c.row_data;
      end
      default: begin
        for (int k = 0; k < RowCount; k++) begin
          w.ram_address = 4'(2 * k);
          w.ram_byte = remapped_row(k);
          w.last = (k == RowCount - 1);
          ram_writes_due.push_back(w);
        end
        updates_sent++;
      end
    endcase
  endfunction

  function automatic frame_cmd_t make_cmd(action_t a, int x, int y, int on, int data);
    frame_cmd_t c;
    c.action = a;
    c.pos_x = 4'(x);
    c.pos_y = 4'(y);
    c.pixel_on = 1'(on);
    c.row_data = 8'(data);
    return c;
  endfunction

  function automatic frame_cmd_t random_cmd();
    frame_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    // Mostly on-frame coordinates so draws and loads actually change pixels.
    c.pos_x = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
    c.pos_y = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
    c.pixel_on = 1'($urandom_range(0, 1));
    c.row_data = 8'($urandom_range(0, 255));
    if (pick < 40) c.action = ACT_DRAW;
    else if (pick < 65) c.action = ACT_LOAD;
    else if (pick < 73) c.action = ACT_FILL;
    else c.action = ACT_UPDATE;
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MaxPrinted) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_ram_write();
    ram_write_t want;
    if (ram_writes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected write, address %0d byte %02h",
                                out_chan.ram_address, out_chan.ram_byte));
      return;
    end
    want = ram_writes_due.pop_front();
    writes_checked++;
    if (out_chan.ram_address !== want.ram_address)
      report_mismatch($sformatf("ram_address got %0d want %0d",
                                out_chan.ram_address, want.ram_address));
    if (out_chan.ram_byte !== want.ram_byte)
      report_mismatch($sformatf("ram_byte got %02h want %02h at address %0d",
                                out_chan.ram_byte, want.ram_byte, want.ram_address));
    if (out_chan.last !== want.last)
      report_mismatch($sformatf("last got %b want %b at address %0d",
                                out_chan.last, want.last, want.ram_address));
  endtask

  // Display RAM side: check each transaction, then draw the next stall.
  always @(posedge clk) begin
    if (!rst && out_chan.valid && out_chan.ready) begin
      check_ram_write();
      sink_wait = sink_gaps_on ? $urandom_range(0, 4) : 0;
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    out_chan.ready <= (sink_wait == 0) && (hold_left == 0);
  end

  task automatic send_cmd(frame_cmd_t c);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= c.action;
    in_chan.pos_x <= c.pos_x;
    in_chan.pos_y <= c.pos_y;
    in_chan.pixel_on <= c.pixel_on;
    in_chan.row_data <= c.row_data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_frame_action(c);
    cmds_sent++;
  endtask

  // Drop valid, drain every due write, then give the output register time to empty.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (ram_writes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rotation(rot_t r);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_rot = r;
  endtask

  task automatic test_directed_cases();
    write_rotation(ROT_0);
    send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_FILL, 15, 15, 1, 255));
    send_cmd(make_cmd(ACT_UPDATE, 15, 15, 1, 255));
    send_cmd(make_cmd(ACT_FILL, 0, 0, 0, 0));
    // corners
    send_cmd(make_cmd(ACT_DRAW, 0, 0, 1, 0));
    send_cmd(make_cmd(ACT_DRAW, 7, 0, 1, 255));
    send_cmd(make_cmd(ACT_DRAW, 0, 7, 1, 0));
    send_cmd(make_cmd(ACT_DRAW, 7, 7, 1, 255));
    // off-frame draws must leave the frame alone
    send_cmd(make_cmd(ACT_DRAW, 8, 3, 1, 0));
    send_cmd(make_cmd(ACT_DRAW, 3, 8, 1, 0));
    send_cmd(make_cmd(ACT_DRAW, 15, 15, 1, 255));
    send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_DRAW, 0, 0, 0, 255));
    send_cmd(make_cmd(ACT_LOAD, 15, 2, 0, 8'hA5));
    send_cmd(make_cmd(ACT_LOAD, 0, 15, 1, 8'hFF));
    send_cmd(make_cmd(ACT_LOAD, 0, 8, 1, 8'h3C));
    send_cmd(make_cmd(ACT_LOAD, 7, 0, 0, 8'h01));
    send_cmd(make_cmd(ACT_LOAD, 0, 7, 1, 8'h80));
    send_cmd(make_cmd(ACT_UPDATE, 15, 15, 1, 255));
  endtask

  task automatic test_each_rotation();
    rot_t order [4] = '{ROT_270, ROT_90, ROT_180, ROT_0};
    foreach (order[i]) begin
      write_rotation(order[i]);
      for (int y = 0; y < RowCount; y++)
        send_cmd(make_cmd(ACT_LOAD, $urandom_range(0, 15), y, $urandom_range(0, 1),
                          $urandom_range(0, 255)));
      send_cmd(make_cmd(ACT_DRAW, $urandom_range(0, 7), $urandom_range(0, 7), 1, 0));
      send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0, 0));
    end
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_rotation(rot_t'($urandom_range(0, 3)));
      // Some phases run back to back on one side or the other.
      src_gaps_on = (p % 3 != 1);
      sink_gaps_on = (p % 3 != 2);
      repeat (per_phase) send_cmd(random_cmd());
    end
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    src_gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 20; i++) begin
      if (i % 6 == 0) send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0, 0));
      else send_cmd(random_cmd());
    end
    src_gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_sender_pause();
    write_rotation(ROT_90);
    repeat (10) send_cmd(random_cmd());
    send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0, 0));
    // hold off until the display writes have all come back
    wait_idle();
    repeat (10) send_cmd(random_cmd());
    send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0, 0));
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.action <= ACT_DRAW;
    in_chan.pos_x <= '0;
    in_chan.pos_y <= '0;
    in_chan.pixel_on <= 1'b0;
    in_chan.row_data <= '0;
    foreach (shadow_rows[j]) shadow_rows[j] = '0;
    shadow_rot = ROT_0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_each_rotation();
    test_random_phases(7, 55);
    test_output_backpressure();
    test_sender_pause();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run covered %0d frame commands, %0d updates and %0d display writes,",
             cmds_sent, updates_sent, writes_checked);
    $display("all four rotations, off-frame edits, output hold-off and sender pauses");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
